### sv/b64d_pkg.sv
// shared types, constants and the character map of the base64 decoder
package b64d_pkg;

    localparam int CHAR_W          = 8;
    localparam int SEXTET_W        = 6;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_TDATA_W     = 16;

    localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;  // '='

    // mapped character: bad flag plus sextet value
    typedef struct packed {
        logic                bad;
        logic [SEXTET_W-1:0] sextet;
    } sextet_t;

    // one request of work from the front part to the back part
    typedef struct packed {
        logic [2:0][7:0] byte_data;   // byte 0 in the lowest slot
        logic [1:0]      byte_count;  // 0 means a bare final result
        logic            done;
        logic            ok;
    } job_t;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic sextet_t map_char(input logic [CHAR_W-1:0] c);
        sextet_t r;
        r.bad    = 1'b0;
        r.sextet = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.sextet = SEXTET_W'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.sextet = SEXTET_W'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r.sextet = SEXTET_W'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            r.sextet = SEXTET_W'(62);
        end
        else if (c == 8'h2F)
        begin
            r.sextet = SEXTET_W'(63);
        end
        else
        begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

### sv/b64d_front.sv
// front part: accepts characters, tracks the quad and builds output requests
module b64d_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [b64d_pkg::CHAR_W-1:0]   character,
    input  logic                          char_present,
    input  logic                          message_end,
    output logic                          job_push,
    output b64d_pkg::job_t                job
);

    logic [1:0]  quad_position_reg, quad_position_next;
    logic [17:0] held_sextets_reg, held_sextets_next;
    logic [1:0]  pad_seen_reg, pad_seen_next;
    logic        error_latched_reg, error_latched_next;

    b64d_pkg::sextet_t mapped;
    logic              is_pad;
    logic              active;
    logic              bad;
    logic [5:0]        sx;
    logic [5:0]        s0, s1, s2;
    logic [1:0]        pad_upd;
    logic [1:0]        pad_cap;
    logic [1:0]        emit_count;

    assign mapped = b64d_pkg::map_char(character);
    assign is_pad = (character == b64d_pkg::CHAR_PAD);
    assign sx     = is_pad ? 6'd0 : mapped.sextet;
    assign active = char_present && !error_latched_reg;
    assign s0     = held_sextets_reg[17:12];
    assign s1     = held_sextets_reg[11:6];
    assign s2     = held_sextets_reg[5:0];

    // classify the character against the quad position and pads seen
    always_comb
    begin
        bad     = 1'b0;
        pad_upd = pad_seen_reg;
        if (quad_position_reg == 2'd0 && pad_seen_reg != 2'd0)
        begin
            bad = 1'b1;
        end
        else if (is_pad)
        begin
            if (quad_position_reg < 2'd2)
                bad = 1'b1;
            else
                pad_upd = pad_seen_reg + 2'd1;
        end
        else if (mapped.bad || pad_seen_reg != 2'd0)
        begin
            bad = 1'b1;
        end
    end

    assign pad_cap    = (pad_upd > 2'd2) ? 2'd2 : pad_upd;
    assign emit_count = 2'd3 - pad_cap;

    // next state and the request for the back part
    always_comb
    begin
        quad_position_next = quad_position_reg;
        held_sextets_next  = held_sextets_reg;
        pad_seen_next      = pad_seen_reg;
        error_latched_next = error_latched_reg;
        job.byte_data[0]   = {s0, s1[5:4]};
        job.byte_data[1]   = {s1[3:0], s2[5:2]};
        job.byte_data[2]   = {s2[1:0], sx};
        job.byte_count     = 2'd0;
        job.done           = 1'b0;
        job.ok             = 1'b0;
        if (active)
        begin
            pad_seen_next = pad_upd;
            if (bad)
            begin
                error_latched_next = 1'b1;
            end
            else if (quad_position_reg < 2'd3)
            begin
                held_sextets_next  = {held_sextets_reg[11:0], sx};
                quad_position_next = quad_position_reg + 2'd1;
            end
            else
            begin
                job.byte_count     = emit_count;
                quad_position_next = 2'd0;
                held_sextets_next  = '0;
            end
        end
        if (message_end)
        begin
            job.done = 1'b1;
            job.ok   = !error_latched_next && quad_position_next == 2'd0;
            quad_position_next = 2'd0;
            held_sextets_next  = '0;
            pad_seen_next      = 2'd0;
            error_latched_next = 1'b0;
        end
    end

    assign job_push = accept && (job.byte_count != 2'd0 || job.done);

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_position_reg <= 2'd0;
            held_sextets_reg  <= '0;
            pad_seen_reg      <= 2'd0;
            error_latched_reg <= 1'b0;
        end
        else if (accept)
        begin
            quad_position_reg <= quad_position_next;
            held_sextets_reg  <= held_sextets_next;
            pad_seen_reg      <= pad_seen_next;
            error_latched_reg <= error_latched_next;
        end
    end

endmodule

### sv/b64d_queue.sv
// short queue of output requests between front and back parts
module b64d_queue
#(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF  // power of two, at least 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output b64d_pkg::job_t pop_data,
    output logic           empty
);

    localparam int AW = $clog2(DEPTH);

    b64d_pkg::job_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (AW+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### sv/b64d_back.sv
// back part: walks the bytes of the head request onto the output stream
module b64d_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    input  b64d_pkg::job_t                       job,
    output logic                                 job_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [b64d_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast
);

    logic [1:0] index_reg, index_next;
    logic       last_of_job;
    logic       take;
    logic [7:0] byte_value;
    logic       byte_valid;

    assign last_of_job = (job.byte_count == 2'd0) || (index_reg == job.byte_count - 2'd1);
    assign take        = m_tvalid && m_tready;
    assign job_pop     = take && last_of_job;

    // result fields
    assign byte_valid = (job.byte_count != 2'd0);
    assign byte_value = byte_valid ? job.byte_data[index_reg] : 8'd0;
    assign m_tvalid   = job_valid;
    assign m_tlast    = last_of_job;
    assign m_tdata    = {5'd0, job.ok && last_of_job, job.done && last_of_job,
                         byte_valid, byte_value};

    // byte index within the request
    always_comb
    begin
        index_next = index_reg;
        if (take)
            index_next = last_of_job ? 2'd0 : index_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= 2'd0;
        else
            index_reg <= index_next;
    end

endmodule

### sv/base64_stream_decoder.sv
// top level of the streaming base64 decoder
//
//  channel  dir  tdata                          tuser         tlast
//  s_       in   [7:0] character                char_present  message_end
//  m_       out  [7:0] byte_value, [8] valid,   -             run_last
//                [9] message_done, [10] ok
//
// one character is taken per cycle while the request queue has room
// a closing quad yields up to three output bytes, one per cycle while the
// output is ready; the output side runs off the queue head and stalls
// without blocking input until the queue fills; reset clears the quad
// state and empties the queue
module base64_stream_decoder
#(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] character
    input  logic                              s_tuser,   // [0] char_present
    input  logic                              s_tlast,   // message_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [b64d_pkg::OUT_TDATA_W-1:0]  m_tdata,   // byte_value, byte_valid,
                                                         // message_done, message_ok
    output logic                              m_tlast    // run_last
);

    b64d_pkg::job_t push_job, head_job;
    logic           push, full, pop, empty;
    logic           accept;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    b64d_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .character    (s_tdata),
        .char_present (s_tuser),
        .message_end  (s_tlast),
        .job_push     (push),
        .job          (push_job)
    );

    b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_job),
        .empty     (empty)
    );

    b64d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!empty),
        .job       (head_job),
        .job_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // success is only reported on a final result
    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10] |-> m_tdata[9])
        else $error("message_ok without message_done");

    // the final result of a message is the last result of its item
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] |-> m_tlast)
        else $error("message_done not on run_last");

    // a result without a byte is always a final one with zero data
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[8] |-> m_tdata[9] && m_tdata[7:0] == 8'd0)
        else $error("byteless result that is not final");

    // input is held off only when the queue is full
    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> s_tready)
        else $error("input stalled with an empty queue");

endmodule
